// ----- hdl/dff_pkg.sv -----
package dff_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ADDR_W = 48;
  localparam int unsigned SEQ_W = 16;
  localparam logic [SEQ_W-1:0] SEQ_TOP = '1;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic table_full_drop;
    logic source_known;
    logic is_new;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// ----- hdl/duplicate_frame_filter.sv -----
// duplicate frame filter, receive side
// slave stream: one transaction per received frame, tdata carries the
//   sender address and the frame's sequence number
// master stream: one transaction per frame with three flags: is_new
//   (forward the frame), source_known (sender was in the table) and
//   table_full_drop (sender was new but the table had no room)
// the sender table lives in a single-port-read memory; a frame is
//   checked by reading the stored senders one per cycle in the order
//   they were added, then writing back the new sequence number when it
//   is newer or appending an unknown sender when there is room
// frames are handled one at a time: a new frame is taken only after the
//   previous result has left the search engine, and the search is paced
//   by the one read per cycle of the table memory
// reset empties the table (entry count cleared, no clearing pass)
// when the receiver stalls, the result waits in the output register
//   and the next frame is still taken and searched; a second finished
//   result waits inside the search engine until the output frees up
module duplicate_frame_filter
  import dff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [47:0] source_address, [63:48] sequence_number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // [0] is_new, [1] source_known, [2] table_full_drop
);

  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     res_valid;
  logic     res_ready;
  result_t  res;

  // output register state
  logic    m_valid_q, m_valid_d;
  result_t m_res_q, m_res_d;

  dff_table u_table (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_addr_i   (s_axis_tdata[ADDR_W-1:0]),
    .in_seq_i    (s_axis_tdata[ADDR_W+SEQ_W-1:ADDR_W]),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // the output slot takes a new result when empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_res_d   = m_res_q;
    if (res_ready) begin
      m_valid_d = res_valid;
      if (res_valid) begin
        m_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'b0, m_res_q.table_full_drop, m_res_q.source_known,
                          m_res_q.is_new};

endmodule

// ----- hdl/dff_table.sv -----
module dff_table
  import dff_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dff_ctrl.sv -----
module dff_ctrl
  import dff_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  logic [SEQ_W-1:0]  in_seq_i,
  output logic              res_valid_o,
  output result_t           res_o,
  input  logic              res_ready_i,
  output mem_req_t          mem_req_o,
  input  entry_t            mem_rdata_i
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic [IDX_W-1:0]  cmp_q, cmp_d;
  logic              rdv_q, rdv_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  result_t           res_q, res_d;

  logic hit;
  logic fresh;
  logic last;

  assign hit   = rdv_q && (mem_rdata_i.addr == addr_q);
  assign fresh = ((mem_rdata_i.seq == SEQ_TOP) && (seq_q < mem_rdata_i.seq)) ||
                 (seq_q > mem_rdata_i.seq);
  assign last  = rdv_q && (CNT_W'(cmp_q) == (count_q - CNT_W'(1)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rdv_q   <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q <= issue_d;
    cmp_q   <= cmp_d;
    addr_q  <= addr_d;
    seq_q   <= seq_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    cmp_d       = cmp_q;
    rdv_d       = 1'b0;
    addr_d      = addr_q;
    seq_d       = seq_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_req_o   = '0;
    mem_req_o.wdata.addr = addr_q;
    mem_req_o.wdata.seq  = seq_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          addr_d  = in_addr_i;
          seq_d   = in_seq_i;
          issue_d = '0;
          state_d = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // one read issued per cycle, compare runs on the registered read data
        if (issue_q < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = issue_q[IDX_W-1:0];
          issue_d         = issue_q + CNT_W'(1);
          cmp_d           = issue_q[IDX_W-1:0];
          rdv_d           = 1'b1;
        end
        if (hit) begin
          mem_req_o.we         = fresh;
          mem_req_o.waddr      = cmp_q;
          res_d.is_new         = fresh;
          res_d.source_known   = 1'b1;
          res_d.table_full_drop = 1'b0;
          rdv_d                = 1'b0;
          state_d              = ST_DONE;
        end else if (last || (count_q == '0)) begin
          res_d.is_new       = 1'b1;
          res_d.source_known = 1'b0;
          rdv_d              = 1'b0;
          if (count_q < CNT_W'(TABLE_ENTRIES)) begin
            mem_req_o.we          = 1'b1;
            mem_req_o.waddr       = count_q[IDX_W-1:0];
            count_d               = count_q + CNT_W'(1);
            res_d.table_full_drop = 1'b0;
          end else begin
            res_d.table_full_drop = 1'b1;
          end
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = res_q;

endmodule

// ----- test/duplicate_frame_filter_chk.sv -----
`timescale 1ns / 100ps

// watches both streams, keeps its own copy of the sender table and
// compares every result transaction with the oldest predicted verdict
module duplicate_frame_filter_chk
  import dff_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [47:0] source_address, [63:48] sequence_number
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,  // [0] is_new, [1] source_known, [2] table_full_drop
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [ADDR_W-1:0] peer_addr [TABLE_ENTRIES];
  logic [SEQ_W-1:0]  peer_seq  [TABLE_ENTRIES];
  logic [CNT_W-1:0]  peer_cnt;
  result_t           verdict_q [$];
  int unsigned       mismatches;

  // search in insertion order, refresh on a newer sequence, append on a miss while there is room
  function automatic result_t judge_frame(input logic [ADDR_W-1:0] addr,
                                          input logic [SEQ_W-1:0]  seq);
    result_t     r;
    logic        hit;
    int unsigned i;
    r   = '0;
    hit = 1'b0;
    for (i = 0; i < 32'(peer_cnt); i++) begin
      if (!hit && peer_addr[i[IDX_W-1:0]] == addr) begin
        hit            = 1'b1;
        r.source_known = 1'b1;
        // a stored top value wraps: anything below it is newer
        if ((peer_seq[i[IDX_W-1:0]] == SEQ_TOP && seq < SEQ_TOP) ||
            seq > peer_seq[i[IDX_W-1:0]]) begin
          r.is_new                = 1'b1;
          peer_seq[i[IDX_W-1:0]] = seq;
        end
      end
    end
    if (!hit) begin
      r.is_new = 1'b1;
      if (peer_cnt < CNT_W'(TABLE_ENTRIES)) begin
        peer_addr[peer_cnt[IDX_W-1:0]] = addr;
        peer_seq[peer_cnt[IDX_W-1:0]]  = seq;
        peer_cnt                       = peer_cnt + CNT_W'(1);
      end else begin
        r.table_full_drop = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      peer_cnt     = '0;
      mismatches   = 0;
      verdict_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // results first: an input taken at this edge cannot have finished yet
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[2:0]);
        if (verdict_q.size() == 0) begin
          $error("result transaction with no frame waiting: %b", m_axis_tdata[2:0]);
          mismatches++;
        end else begin
          want = verdict_q[0];
          verdict_q.delete(0);
          if (got.is_new !== want.is_new) begin
            $error("is_new: expected %0b, got %0b", want.is_new, got.is_new);
            mismatches++;
          end
          if (got.source_known !== want.source_known) begin
            $error("source_known: expected %0b, got %0b",
                   want.source_known, got.source_known);
            mismatches++;
          end
          if (got.table_full_drop !== want.table_full_drop) begin
            $error("table_full_drop: expected %0b, got %0b",
                   want.table_full_drop, got.table_full_drop);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        verdict_q.insert(verdict_q.size(),
                         judge_frame(s_axis_tdata[ADDR_W-1:0],
                                     s_axis_tdata[ADDR_W+SEQ_W-1:ADDR_W]));
      fail_count_o <= mismatches;
      pending_o    <= verdict_q.size();
    end
  end

endmodule

// ----- test/duplicate_frame_filter_tb.sv -----
`timescale 1ns / 100ps

module duplicate_frame_filter_tb
  import dff_pkg::*;
;

  localparam int unsigned RANDOM_FRAMES  = 1400;
  localparam int unsigned PEER_POOL      = 30;
  localparam int unsigned DRAIN_CYCLES   = 64;    // a full table scan plus margin
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned CALM_FIRST     = 600;   // stretch with no idling on either side
  localparam int unsigned CALM_LAST      = 899;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [47:0] source_address, [63:48] sequence_number
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] is_new, [1] source_known, [2] table_full_drop
  logic        calm;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  logic [ADDR_W-1:0] pool_addr [PEER_POOL];
  logic [SEQ_W-1:0]  pool_seq  [PEER_POOL];

  duplicate_frame_filter dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  duplicate_frame_filter_chk chk (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // receiver stalls about one cycle in ten outside the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 10);
  end

  // watchdog on cycles where neither stream moves a transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] random_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // one frame transaction; valid stays high between back-to-back frames
  task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [SEQ_W-1:0] seq);
    if (!calm && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {seq, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // frame from a sender of the pool, remembering the last sequence sent
  task automatic offer_peer(input int unsigned idx, input logic [SEQ_W-1:0] seq);
    pool_seq[idx] = seq;
    send_frame(pool_addr[idx], seq);
  endtask

  initial begin
    int unsigned n;
    int unsigned idx;
    logic [SEQ_W-1:0] seq;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    calm          = 1'b0;

    // first four senders: address extremes and a pair one bit apart
    pool_addr[0] = '0;
    pool_addr[1] = '1;
    pool_addr[2] = 48'h0123_4567_89ab;
    pool_addr[3] = 48'h0123_4567_89aa;
    // the rest: half random, half one bit away from a neighbor
    for (n = 4; n < PEER_POOL; n++)
      pool_addr[n] = n[0] ? pool_addr[n-1] ^ (48'h1 << $urandom_range(ADDR_W - 1))
                          : random_addr();
    for (n = 0; n < PEER_POOL; n++)
      pool_seq[n] = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss, equal, greater, smaller
    offer_peer(0, 16'h0000);
    offer_peer(0, 16'h0000);
    offer_peer(0, 16'h0001);
    offer_peer(0, 16'h0000);
    // top sequence: second top is a duplicate, then wraparound both ways
    offer_peer(1, SEQ_TOP);
    offer_peer(1, SEQ_TOP);
    offer_peer(1, 16'h0000);
    offer_peer(1, 16'h0000);
    offer_peer(1, SEQ_TOP);
    offer_peer(1, 16'hfffe);
    offer_peer(1, SEQ_TOP);
    // neighbors differing in the lowest address bit stay apart, then more checks on senders 0 and 2
    offer_peer(2, 16'h8000);
    offer_peer(3, 16'h7fff);
    offer_peer(2, 16'h7fff);
    offer_peer(3, 16'h8000);
    offer_peer(0, 16'hffff);
    offer_peer(0, 16'hfffe);
    offer_peer(2, 16'h5555);
    offer_peer(2, 16'haaaa);

    // random: mostly known senders with sequences often near the last one,
    // some unknown senders that fill the table and then get dropped
    for (n = 0; n < RANDOM_FRAMES; n++) begin
      calm <= (n >= CALM_FIRST && n <= CALM_LAST);
      if ($urandom_range(99) < 12) begin
        send_frame(random_addr(), SEQ_W'($urandom));
      end else begin
        idx = $urandom_range(PEER_POOL - 1);
        case ($urandom_range(7))
          0:       seq = pool_seq[idx];
          1:       seq = pool_seq[idx] + SEQ_W'(1);
          2:       seq = pool_seq[idx] + SEQ_W'($urandom_range(2, 300));
          3:       seq = pool_seq[idx] - SEQ_W'(1);
          4:       seq = SEQ_TOP;
          5:       seq = '0;
          default: seq = SEQ_W'($urandom);
        endcase
        offer_peer(idx, seq);
      end
    end
    s_axis_tvalid <= 1'b0;
    calm          <= 1'b0;
    // let the checker count the last frame before waiting on it
    @(posedge clk_i);

    // drain, then let any stray result show up
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/dff_pkg.sv
hdl/dff_table.sv
hdl/dff_ctrl.sv
hdl/duplicate_frame_filter.sv
test/duplicate_frame_filter_chk.sv
test/duplicate_frame_filter_tb.sv
